FILE: rtl/dsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and constants for the shortest-path engine
// Sizes, operation codes, beat layouts and controller/datapath links.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int NV  = 64;
  localparam int NE  = 256;
  localparam int WB  = 16;
  localparam int DB  = 24;
  localparam int VW  = 6;
  localparam int VIW = $clog2(NV);
  localparam int VCW = $clog2(NV + 1);
  localparam int EIW = $clog2(NE);
  localparam int ECW = $clog2(NE + 1);

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]    operation;
    logic [VW-1:0] vertex_a;
    logic [VW-1:0] vertex_b;
    logic [WB-1:0] weight;
  } dsp_in_t;

  typedef struct packed {
    logic [DB-1:0] distance;
    logic          reachable;
    logic          edges_dropped;
  } dsp_out_t;

  typedef struct packed {
    logic [VIW-1:0] end_a;
    logic [VIW-1:0] end_b;
    logic [WB-1:0]  cost;
  } dsp_edge_t;

  localparam int EDGE_W = $bits(dsp_edge_t);

  typedef struct packed {
    logic accept;
    logic init;
    logic scan;
    logic pick;
    logic eaddr;
    logic edat;
    logic relax;
    logic fin;
    logic load;
  } dsp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic no_edges;
    logic last_edge;
    logic out_free;
  } dsp_sts_t;

endpackage

FILE: rtl/dsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dsp_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/dsp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_ctrl: query sequencer
// Steps a query through vertex scans, edge relaxation and result load.
// ----------------------------------------------------------------------------
module dsp_ctrl import dsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  input  dsp_sts_t   sts,
  output dsp_cmd_t   cmd,
  output logic       in_stall
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_INIT  = 9'b000000010,
    ST_SCAN  = 9'b000000100,
    ST_PICK  = 9'b000001000,
    ST_EADDR = 9'b000010000,
    ST_EDATA = 9'b000100000,
    ST_RELAX = 9'b001000000,
    ST_FIN   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid && in_op == OP_QUERY) state_nxt = ST_INIT;
      ST_INIT:  state_nxt = ST_SCAN;
      ST_SCAN:  if (sts.scan_done) state_nxt = ST_PICK;
      ST_PICK: begin
        if (!sts.found) state_nxt = ST_FIN;
        else if (sts.no_edges) state_nxt = ST_SCAN;
        else state_nxt = ST_EADDR;
      end
      ST_EADDR: state_nxt = ST_EDATA;
      ST_EDATA: state_nxt = ST_RELAX;
      ST_RELAX: state_nxt = sts.last_edge ? ST_SCAN : ST_EADDR;
      ST_FIN:   state_nxt = ST_OUT;
      ST_OUT:   if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign cmd.accept = (state_r == ST_IDLE) && in_valid;
  assign cmd.init   = (state_r == ST_INIT);
  assign cmd.scan   = (state_r == ST_SCAN);
  assign cmd.pick   = (state_r == ST_PICK);
  assign cmd.eaddr  = (state_r == ST_EADDR);
  assign cmd.edat   = (state_r == ST_EDATA);
  assign cmd.relax  = (state_r == ST_RELAX);
  assign cmd.fin    = (state_r == ST_FIN);
  assign cmd.load   = (state_r == ST_OUT) && sts.out_free;

endmodule

FILE: rtl/dsp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_dp: shortest-path datapath
// Edge store, distance store, per-vertex marks, minimum scan, relaxation
// and the result register.
// ----------------------------------------------------------------------------
module dsp_dp import dsp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dsp_cmd_t cmd,
  output dsp_sts_t sts,
  input  dsp_in_t  in_beat,
  output logic     out_valid,
  input  logic     out_stall,
  output dsp_out_t out_beat
);

  logic [ECW-1:0] ecnt_r;
  logic           ovf_r;
  logic [VIW-1:0] src_r, dst_r;
  logic           qok_r;
  logic [NV-1:0]  reached_r, visited_r;
  logic [VCW-1:0] vcnt_r;
  logic           pend_r;
  logic [VIW-1:0] idx_d_r;
  logic           found_r;
  logic [VIW-1:0] best_r;
  logic [DB-1:0]  best_d_r;
  logic [ECW-1:0] eidx_r;
  logic [VIW-1:0] other_r;
  logic [WB-1:0]  cost_r;
  logic           hit_r;
  logic           out_valid_r;
  dsp_out_t       out_beat_r;

  logic              a_ok, b_ok, room;
  logic              edge_we;
  dsp_edge_t         edge_wr, edge_rd;
  logic [EDGE_W-1:0] edge_rdata;
  logic              dist_we;
  logic [VIW-1:0]    dist_waddr, dist_raddr;
  logic [DB-1:0]     dist_wdata, dist_rd;
  logic              take;
  logic              hit_a, hit_b;
  logic [VIW-1:0]    other;
  logic [DB:0]       cand_w;
  logic [DB-1:0]     cand;
  logic              upd;
  logic              reach;

  assign a_ok = VCW'(in_beat.vertex_a) < VCW'(NV);
  assign b_ok = VCW'(in_beat.vertex_b) < VCW'(NV);
  assign room = ecnt_r < ECW'(NE);

  assign edge_we = cmd.accept && in_beat.operation == OP_ADD && a_ok && b_ok && room;
  assign edge_wr.end_a = in_beat.vertex_a[VIW-1:0];
  assign edge_wr.end_b = in_beat.vertex_b[VIW-1:0];
  assign edge_wr.cost  = in_beat.weight[WB-1:0];

  dsp_ram #(.W(EDGE_W), .D(NE)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (ecnt_r[EIW-1:0]),
    .wdata (edge_wr),
    .raddr (eidx_r[EIW-1:0]),
    .rdata (edge_rdata)
  );

  assign edge_rd = dsp_edge_t'(edge_rdata);

  // minimum scan, lowest index wins ties
  assign take = pend_r && reached_r[idx_d_r] && !visited_r[idx_d_r]
             && (!found_r || dist_rd < best_d_r);

  assign hit_a = (edge_rd.end_a == best_r);
  assign hit_b = (edge_rd.end_b == best_r);
  assign other = hit_a ? edge_rd.end_b : edge_rd.end_a;

  assign cand_w = {1'b0, best_d_r} + (DB+1)'(cost_r);
  assign cand   = cand_w[DB] ? {DB{1'b1}} : cand_w[DB-1:0];
  assign upd    = cmd.relax && hit_r && (!reached_r[other_r] || cand < dist_rd);

  assign dist_we    = (cmd.init && qok_r) || upd;
  assign dist_waddr = cmd.init ? src_r : other_r;
  assign dist_wdata = cmd.init ? '0 : cand;

  always_comb begin
    if (cmd.scan) dist_raddr = vcnt_r[VIW-1:0];
    else if (cmd.edat) dist_raddr = other;
    else dist_raddr = dst_r;
  end

  dsp_ram #(.W(DB), .D(NV)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rd)
  );

  assign sts.scan_done = (vcnt_r == VCW'(NV));
  assign sts.found     = found_r;
  assign sts.no_edges  = (ecnt_r == '0);
  assign sts.last_edge = (ECW'(eidx_r + 1'b1) == ecnt_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign reach = qok_r && reached_r[dst_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecnt_r      <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      vcnt_r      <= '0;
      eidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        case (in_beat.operation)
          OP_ADD: begin
            if (a_ok && b_ok) begin
              if (room) ecnt_r <= ECW'(ecnt_r + 1'b1);
              else ovf_r <= 1'b1;
            end
          end
          OP_CLEAR: ecnt_r <= '0;
          default: ;
        endcase
      end
      pend_r <= cmd.scan && !sts.scan_done;
      if (cmd.init || cmd.pick) begin
        vcnt_r  <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.scan && !sts.scan_done) vcnt_r <= VCW'(vcnt_r + 1'b1);
        if (take) found_r <= 1'b1;
      end
      if (cmd.pick) eidx_r <= '0;
      else if (cmd.relax) eidx_r <= ECW'(eidx_r + 1'b1);
      if (cmd.load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_beat.operation == OP_QUERY) begin
      src_r <= in_beat.vertex_a[VIW-1:0];
      dst_r <= in_beat.vertex_b[VIW-1:0];
      qok_r <= a_ok && b_ok;
    end
    if (cmd.init) begin
      reached_r <= qok_r ? (NV'(1) << src_r) : '0;
      visited_r <= '0;
    end
    if (take) begin
      best_r   <= idx_d_r;
      best_d_r <= dist_rd;
    end
    if (cmd.pick && found_r) visited_r[best_r] <= 1'b1;
    idx_d_r <= vcnt_r[VIW-1:0];
    if (cmd.edat) begin
      other_r <= other;
      cost_r  <= edge_rd.cost;
      hit_r   <= hit_a ^ hit_b;
    end
    if (upd) reached_r[other_r] <= 1'b1;
    if (cmd.load) begin
      out_beat_r.distance      <= reach ? dist_rd : {DB{1'b1}};
      out_beat_r.reachable     <= reach;
      out_beat_r.edges_dropped <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

FILE: rtl/dijkstra_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dijkstra_shortest_path: single-source shortest-path engine
// Add edge and clear take one beat per cycle while no query is in progress.
// A query runs one round per visited vertex plus one final round, each a
// vertex scan on the distance RAM read port; each relaxation pass steps every
// stored edge through the address, data and relax states. Reset clears edge
// count, drop flag and control; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module dijkstra_shortest_path import dsp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dsp_in_t  in_beat,
  output logic     out_valid,
  input  logic     out_stall,
  output dsp_out_t out_beat
);

  dsp_cmd_t cmd;
  dsp_sts_t sts;

  dsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_beat.operation),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  dsp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command active");

  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_beat.operation == OP_QUERY |=> in_stall)
    else $error("query beat did not block the input");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.load))
    else $error("result beat without a load");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

endmodule
